@@ hdl/ccwd_pkg.sv @@
// ----------------------------------------------------------------------------
// ccwd_pkg
// Shared types, register offsets and the main divider decode helper for the
// clock control and watchdog register block.
// ----------------------------------------------------------------------------
package ccwd_pkg;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [9:0] ADDR_PM1   = 10'h005;
  localparam logic [9:0] ADDR_CM0   = 10'h006;
  localparam logic [9:0] ADDR_CM1   = 10'h007;
  localparam logic [9:0] ADDR_MCD   = 10'h00c;
  localparam logic [9:0] ADDR_CM2   = 10'h00d;
  localparam logic [9:0] ADDR_WDTS  = 10'h00e;
  localparam logic [9:0] ADDR_WDC   = 10'h00f;
  localparam logic [9:0] ADDR_PM2   = 10'h013;
  localparam logic [9:0] ADDR_PLC0  = 10'h026;
  localparam logic [9:0] ADDR_PLC1  = 10'h027;

  localparam logic [14:0] WDT_RELOAD = 15'h7fff;

  typedef struct packed {
    logic [1:0] mode;
    logic [9:0] address;
    logic [7:0] write_data;
    logic       protect_open;
    logic       cpu_tick;
    logic       ring_tick;
  } item_t;

  typedef struct packed {
    logic ring_mode;
    logic div128;
    logic load;
  } wdt_ctrl_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       write_blocked;
    logic       watchdog_reset;
    logic [4:0] main_divide;
    logic [3:0] pll_multiply;
    logic [1:0] pll_divide;
    logic [5:0] clock_selects;
    logic [1:0] f2n_select;
    logic       config_error;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] value;
  } div_dec_t;

  function automatic div_dec_t decode_div(input logic [7:0] code);
    div_dec_t r;
    r.ok    = 1'b1;
    r.value = code[4:0];
    case (code[4:0])
      5'h12: r.value = 5'd1;
      5'h00: r.value = 5'd16;
      5'h02, 5'h03, 5'h04, 5'h06, 5'h08, 5'h0a, 5'h0c, 5'h0e: r.value = code[4:0];
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/clock_control_and_watchdog_regs.sv @@
// ----------------------------------------------------------------------------
// clock_control_and_watchdog_regs
// Each item passes the input register, then the result register; a held
// result stalls the input register while the receiver is not ready.
// Throughput: one item per cycle while the receiver is ready, limited by the
// single register update pass. Reset: asynchronous, active low; registers
// take their documented values and the watchdog is stopped at zero.
// ----------------------------------------------------------------------------
module clock_control_and_watchdog_regs (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [9:0] address_i,
  input  logic [7:0] write_data_i,
  input  logic       protect_open_i,
  input  logic       cpu_tick_i,
  input  logic       ring_tick_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       write_blocked_o,
  output logic       watchdog_reset_o,
  output logic [4:0] main_divide_o,
  output logic [3:0] pll_multiply_o,
  output logic [1:0] pll_divide_o,
  output logic [5:0] clock_selects_o,
  output logic [1:0] f2n_select_o,
  output logic       config_error_o
);
  import ccwd_pkg::*;

  logic      in_valid_q, out_valid_q, fire;
  item_t     item_q;
  result_t   res, res_q;
  wdt_ctrl_t wdt_ctrl;
  logic [4:0] count_hi;
  logic      wreset;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{mode: mode_i, address: address_i, write_data: write_data_i,
                  protect_open: protect_open_i, cpu_tick: cpu_tick_i,
                  ring_tick: ring_tick_i};
    end
    if (fire) res_q <= res;
  end

  ccwd_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (item_q),
    .count_hi_i (count_hi),
    .wreset_i   (wreset),
    .wdt_ctrl_o (wdt_ctrl),
    .result_o   (res)
  );

  ccwd_wdt u_wdt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .tick_i      (item_q.mode == MODE_TICK),
    .cpu_tick_i  (item_q.cpu_tick),
    .ring_tick_i (item_q.ring_tick),
    .ctrl_i      (wdt_ctrl),
    .count_hi_o  (count_hi),
    .wreset_o    (wreset)
  );

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = res_q.read_data;
  assign write_blocked_o  = res_q.write_blocked;
  assign watchdog_reset_o = res_q.watchdog_reset;
  assign main_divide_o    = res_q.main_divide;
  assign pll_multiply_o   = res_q.pll_multiply;
  assign pll_divide_o     = res_q.pll_divide;
  assign clock_selects_o  = res_q.clock_selects;
  assign f2n_select_o     = res_q.f2n_select;
  assign config_error_o   = res_q.config_error;

endmodule

@@ hdl/ccwd_wdt.sv @@
// ----------------------------------------------------------------------------
// ccwd_wdt
// Watchdog down-counter with CPU tick prescaler and ring oscillator mode.
// ----------------------------------------------------------------------------
module ccwd_wdt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic                tick_i,
  input  logic                cpu_tick_i,
  input  logic                ring_tick_i,
  input  ccwd_pkg::wdt_ctrl_t ctrl_i,
  output logic [4:0]          count_hi_o,
  output logic                wreset_o
);
  import ccwd_pkg::*;

  logic [14:0] count_q, count_d;
  logic [6:0]  presc_q, presc_d;
  logic [7:0]  presc_inc;
  logic [7:0]  presc_lim;
  logic        step;

  assign presc_inc = {1'b0, presc_q} + 8'd1;
  assign presc_lim = ctrl_i.div128 ? 8'd128 : 8'd16;

  always_comb begin
    presc_d = presc_q;
    step    = 1'b0;
    if (tick_i) begin
      if (ctrl_i.ring_mode) begin
        step = ring_tick_i;
      end else if (cpu_tick_i) begin
        if (presc_inc >= presc_lim) begin
          presc_d = '0;
          step    = 1'b1;
        end else begin
          presc_d = presc_inc[6:0];
        end
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    wreset_o = 1'b0;
    if (ctrl_i.load) begin
      count_d = WDT_RELOAD;
    end else if (step && (count_q != '0)) begin
      count_d  = count_q - 15'd1;
      wreset_o = (count_q == 15'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      presc_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
      presc_q <= presc_d;
    end
  end

  assign count_hi_o = count_q[14:10];

endmodule

@@ hdl/ccwd_regs.sv @@
// ----------------------------------------------------------------------------
// ccwd_regs
// Clock control register file: protected writes, divider and PLL decode,
// read mux and result assembly.
// ----------------------------------------------------------------------------
module ccwd_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  ccwd_pkg::item_t     item_i,
  input  logic [4:0]          count_hi_i,
  input  logic                wreset_i,
  output ccwd_pkg::wdt_ctrl_t wdt_ctrl_o,
  output ccwd_pkg::result_t   result_o
);
  import ccwd_pkg::*;

  logic [7:0] pm1_q, pm1_d, cm0_q, cm0_d, cm1_q, cm1_d, mcd_q, mcd_d;
  logic [7:0] cm2_q, cm2_d, plc0_q, plc0_d, plc1_q, plc1_d, pm2_q, pm2_d;
  logic [7:0] wdc_q, wdc_d;
  logic [4:0] div_q, div_d;
  logic [3:0] mul_q, mul_d;
  logic [1:0] pdiv_q, pdiv_d;

  logic       is_write, prot, blocked, wr_en, err;
  logic       pll_dec;
  logic [3:0] mul_new;
  div_dec_t   ddec;
  logic [7:0] rd;

  assign is_write = (item_i.mode == MODE_WRITE);
  assign prot = (item_i.address == ADDR_CM0) || (item_i.address == ADDR_CM1) ||
                (item_i.address == ADDR_MCD) || (item_i.address == ADDR_CM2) ||
                (item_i.address == ADDR_PLC0) || (item_i.address == ADDR_PLC1);
  assign blocked = is_write && prot && !item_i.protect_open;
  assign wr_en   = is_write && !blocked;
  assign ddec    = decode_div(item_i.write_data);

  always_comb begin
    pm1_d   = pm1_q;
    cm0_d   = cm0_q;
    cm1_d   = cm1_q;
    mcd_d   = mcd_q;
    cm2_d   = cm2_q;
    plc0_d  = plc0_q;
    plc1_d  = plc1_q;
    pm2_d   = pm2_q;
    wdc_d   = wdc_q;
    div_d   = div_q;
    mul_d   = mul_q;
    pdiv_d  = pdiv_q;
    err     = 1'b0;
    pll_dec = 1'b0;
    if (wr_en) begin
      unique case (item_i.address)
        ADDR_PM1: pm1_d = item_i.write_data;
        ADDR_CM0: cm0_d = item_i.write_data;
        ADDR_CM1: cm1_d = item_i.write_data;
        ADDR_CM2: cm2_d = item_i.write_data;
        ADDR_MCD: begin
          if (item_i.write_data != mcd_q) begin
            mcd_d = item_i.write_data;
            if (ddec.ok) div_d = ddec.value;
            else err = 1'b1;
          end
        end
        ADDR_PLC0: begin
          if (item_i.write_data != plc0_q) begin
            plc0_d  = item_i.write_data;
            pll_dec = 1'b1;
          end
        end
        ADDR_PLC1: begin
          if (item_i.write_data != plc1_q) begin
            plc1_d  = item_i.write_data;
            pll_dec = 1'b1;
          end
        end
        ADDR_PM2: pm2_d = item_i.write_data | (pm2_q & 8'h06);
        ADDR_WDC: wdc_d = (item_i.write_data & 8'he0) | 8'h20;
        default: ;
      endcase
    end
    mul_new = {plc0_d[2:0], 1'b0};
    if (pll_dec) begin
      if ((mul_new == 4'd6) || (mul_new == 4'd8)) begin
        mul_d  = mul_new;
        pdiv_d = plc1_d[2] ? 2'd3 : 2'd2;
      end else begin
        err = 1'b1;
      end
    end
  end

  always_comb begin
    rd = '0;
    if (item_i.mode == MODE_READ) begin
      unique case (item_i.address)
        ADDR_PM1:  rd = pm1_q;
        ADDR_CM0:  rd = cm0_q;
        ADDR_CM1:  rd = cm1_q;
        ADDR_MCD:  rd = mcd_q;
        ADDR_CM2:  rd = cm2_q;
        ADDR_WDC:  rd = {wdc_q[7:5], count_hi_i};
        ADDR_PM2:  rd = pm2_q;
        ADDR_PLC0: rd = plc0_q;
        ADDR_PLC1: rd = plc1_q;
        default:   rd = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm1_q  <= 8'h00;
      cm0_q  <= 8'h08;
      cm1_q  <= 8'h20;
      mcd_q  <= 8'h08;
      cm2_q  <= 8'h00;
      plc0_q <= 8'h12;
      plc1_q <= 8'h00;
      pm2_q  <= 8'h00;
      wdc_q  <= 8'h00;
      div_q  <= 5'd8;
      mul_q  <= 4'd0;
      pdiv_q <= 2'd0;
    end else if (fire_i) begin
      pm1_q  <= pm1_d;
      cm0_q  <= cm0_d;
      cm1_q  <= cm1_d;
      mcd_q  <= mcd_d;
      cm2_q  <= cm2_d;
      plc0_q <= plc0_d;
      plc1_q <= plc1_d;
      pm2_q  <= pm2_d;
      wdc_q  <= wdc_d;
      div_q  <= div_d;
      mul_q  <= mul_d;
      pdiv_q <= pdiv_d;
    end
  end

  assign wdt_ctrl_o.ring_mode = pm2_q[2];
  assign wdt_ctrl_o.div128    = wdc_q[7];
  assign wdt_ctrl_o.load      = wr_en && (item_i.address == ADDR_WDTS);

  assign result_o.read_data      = rd;
  assign result_o.write_blocked  = blocked;
  assign result_o.watchdog_reset = wreset_i;
  assign result_o.main_divide    = div_d;
  assign result_o.pll_multiply   = mul_d;
  assign result_o.pll_divide     = pdiv_d;
  assign result_o.clock_selects  = {pm2_d[2], pm2_d[5], pm2_d[4], cm2_d[1], cm1_d[7], cm0_d[7]};
  assign result_o.f2n_select     = pm2_d[7:6];
  assign result_o.config_error   = err;

endmodule

@@ tb/tb_clock_control_and_watchdog_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_control_and_watchdog_regs
// Self-checking bench for the clock control and watchdog register block.
// A table of directed accesses runs first. Random register traffic follows,
// in CPU-prescaler watchdog mode and then with ring mode allowed. A
// ring-oscillator run near the end steps the watchdog count down. Every
// result is checked field by field against its table row or the bench model.
// ----------------------------------------------------------------------------
module tb_clock_control_and_watchdog_regs;
  import ccwd_pkg::*;

  localparam logic [1:0] MODE_NONE  = 2'd3;
  localparam logic [9:0] ADDR_TCSPR = 10'h35f;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] mode_i;
  logic [9:0] address_i;
  logic [7:0] write_data_i;
  logic       protect_open_i;
  logic       cpu_tick_i;
  logic       ring_tick_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] read_data_o;
  logic       write_blocked_o;
  logic       watchdog_reset_o;
  logic [4:0] main_divide_o;
  logic [3:0] pll_multiply_o;
  logic [1:0] pll_divide_o;
  logic [5:0] clock_selects_o;
  logic [1:0] f2n_select_o;
  logic       config_error_o;

  clock_control_and_watchdog_regs dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .address_i       (address_i),
    .write_data_i    (write_data_i),
    .protect_open_i  (protect_open_i),
    .cpu_tick_i      (cpu_tick_i),
    .ring_tick_i     (ring_tick_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_data_o     (read_data_o),
    .write_blocked_o (write_blocked_o),
    .watchdog_reset_o(watchdog_reset_o),
    .main_divide_o   (main_divide_o),
    .pll_multiply_o  (pll_multiply_o),
    .pll_divide_o    (pll_divide_o),
    .clock_selects_o (clock_selects_o),
    .f2n_select_o    (f2n_select_o),
    .config_error_o  (config_error_o)
  );

  // register image
  logic [7:0]  pm1, cm0, cm1, mcd, cm2, plc0, plc1, pm2, wdc;
  logic [14:0] wdt_cnt;
  logic [6:0]  presc_cnt;
  logic [4:0]  div_eff;
  logic [3:0]  pll_mul_eff;
  logic [1:0]  pll_div_eff;

  result_t due_results[$];
  row_t    dir_rows[$];
  int      err_cnt = 0;
  int      burst_left = 0;
  logic [15:0] stall_pat = 16'hffff;
  logic [3:0]  stall_idx = '0;

  logic [9:0] map_addr[11] = '{ADDR_PM1, ADDR_CM0, ADDR_CM1, ADDR_MCD, ADDR_CM2, ADDR_WDTS,
                               ADDR_WDC, ADDR_PM2, ADDR_PLC0, ADDR_PLC1, ADDR_TCSPR};
  logic [4:0] legal_mcd[10] = '{5'h12, 5'h00, 5'h02, 5'h03, 5'h04, 5'h06, 5'h08, 5'h0a,
                                5'h0c, 5'h0e};

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic regs_reset();
    pm1 = 8'h00; cm0 = 8'h08; cm1 = 8'h20; mcd = 8'h08; cm2 = 8'h00;
    plc0 = 8'h12; plc1 = 8'h00; pm2 = 8'h00; wdc = 8'h00;
    wdt_cnt = '0; presc_cnt = '0;
    div_eff = 5'd8; pll_mul_eff = '0; pll_div_eff = '0;
  endtask

  function automatic logic [7:0] reg_byte(logic [9:0] a);
    case (a)
      ADDR_PM1:  return pm1;
      ADDR_CM0:  return cm0;
      ADDR_CM1:  return cm1;
      ADDR_MCD:  return mcd;
      ADDR_CM2:  return cm2;
      ADDR_WDC:  return {wdc[7:5], wdt_cnt[14:10]};
      ADDR_PM2:  return pm2;
      ADDR_PLC0: return plc0;
      ADDR_PLC1: return plc1;
      default:   return 8'h00;
    endcase
  endfunction

  task automatic decode_main_div(output logic bad);
    bad = 1'b0;
    case (mcd[4:0])
      5'h12: div_eff = 5'd1;
      5'h00: div_eff = 5'd16;
      5'h02, 5'h03, 5'h04, 5'h06, 5'h08, 5'h0a, 5'h0c, 5'h0e: div_eff = mcd[4:0];
      default: bad = 1'b1;
    endcase
  endtask

  task automatic decode_pll(output logic bad);
    logic [3:0] mul;
    mul = {plc0[2:0], 1'b0};
    bad = !(mul == 4'd6 || mul == 4'd8);
    if (!bad) begin
      pll_mul_eff = mul;
      pll_div_eff = plc1[2] ? 2'd3 : 2'd2;
    end
  endtask

  task automatic wdt_decrement(output logic hit);
    hit = 1'b0;
    if (wdt_cnt != '0) begin
      wdt_cnt = wdt_cnt - 15'd1;
      hit = (wdt_cnt == '0);
    end
  endtask

  task automatic regs_step(input item_t it, output result_t r);
    int unsigned p, lim;
    logic bad;
    r = '0;
    case (it.mode)
      MODE_READ: r.read_data = reg_byte(it.address);
      MODE_WRITE: begin
        if (it.address inside {ADDR_CM0, ADDR_CM1, ADDR_MCD, ADDR_CM2, ADDR_PLC0, ADDR_PLC1}
            && !it.protect_open) begin
          r.write_blocked = 1'b1;
        end else begin
          case (it.address)
            ADDR_PM1: pm1 = it.write_data;
            ADDR_CM0: cm0 = it.write_data;
            ADDR_CM1: cm1 = it.write_data;
            ADDR_CM2: cm2 = it.write_data;
            ADDR_MCD: if (it.write_data != mcd) begin
              mcd = it.write_data;
              decode_main_div(bad);
              r.config_error = bad;
            end
            ADDR_PLC0: if (it.write_data != plc0) begin
              plc0 = it.write_data;
              decode_pll(bad);
              r.config_error = bad;
            end
            ADDR_PLC1: if (it.write_data != plc1) begin
              plc1 = it.write_data;
              decode_pll(bad);
              r.config_error = bad;
            end
            ADDR_PM2:  pm2 = it.write_data | (pm2 & 8'h06);
            ADDR_WDC:  wdc = (it.write_data & 8'he0) | 8'h20;
            ADDR_WDTS: wdt_cnt = WDT_RELOAD;
            default: ;
          endcase
        end
      end
      MODE_TICK: begin
        if (pm2[2]) begin
          if (it.ring_tick) wdt_decrement(r.watchdog_reset);
        end else if (it.cpu_tick) begin
          lim = wdc[7] ? 128 : 16;
          p = presc_cnt + 1;
          if (p >= lim) begin
            presc_cnt = '0;
            wdt_decrement(r.watchdog_reset);
          end else begin
            presc_cnt = p[6:0];
          end
        end
      end
      default: ;
    endcase
    r.main_divide   = div_eff;
    r.pll_multiply  = pll_mul_eff;
    r.pll_divide    = pll_div_eff;
    r.clock_selects = {pm2[2], pm2[5], pm2[4], cm2[1], cm1[7], cm0[7]};
    r.f2n_select    = pm2[7:6];
  endtask

  function automatic item_t mk_item(logic [1:0] m, logic [9:0] a, logic [7:0] d,
                                    logic open, logic cpu, logic ring);
    item_t it;
    it.mode = m; it.address = a; it.write_data = d;
    it.protect_open = open; it.cpu_tick = cpu; it.ring_tick = ring;
    return it;
  endfunction

  function automatic result_t at_reset(logic [7:0] rd, logic blocked, logic cfg_err);
    result_t r;
    r = '0;
    r.read_data = rd; r.write_blocked = blocked; r.config_error = cfg_err;
    r.main_divide = 5'd8;
    return r;
  endfunction

  task automatic add_row(item_t it, logic typed, result_t res);
    row_t row;
    row.it = it; row.typed = typed; row.res = res;
    dir_rows.push_back(row);
  endtask

  function automatic item_t rand_item(logic ring_ok);
    item_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it = mk_item(MODE_READ, map_addr[$urandom_range(0, 10)], 8'($urandom),
                 $urandom_range(0, 3) != 0, 1'($urandom), 1'($urandom));
    if (r < 45) begin
      it.mode = MODE_TICK;
      it.cpu_tick = ($urandom_range(0, 7) != 0);
    end else if (r < 72) begin
      it.mode = MODE_WRITE;
      if (it.address == ADDR_MCD && $urandom_range(0, 1))
        it.write_data = {it.write_data[7:5], legal_mcd[$urandom_range(0, 9)]};
      if (it.address == ADDR_PLC0 && $urandom_range(0, 1))
        it.write_data = {it.write_data[7:3], ($urandom_range(0, 1) ? 3'd3 : 3'd4)};
    end else if (r >= 92) begin
      it.mode = 2'($urandom);
      it.address = 10'($urandom);
    end
    if (!ring_ok && it.mode == MODE_WRITE && it.address == ADDR_PM2)
      it.write_data[2] = 1'b0;
    return it;
  endfunction

  task automatic pace();
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_item(input item_t it, input logic typed, input result_t typed_res,
                           output result_t pred);
    pace();
    in_valid_i     <= 1'b1;
    mode_i         <= it.mode;
    address_i      <= it.address;
    write_data_i   <= it.write_data;
    protect_open_i <= it.protect_open;
    cpu_tick_i     <= it.cpu_tick;
    ring_tick_i    <= it.ring_tick;
    do @(posedge clk_i); while (!in_ready_o);
    regs_step(it, pred);
    due_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic report_mismatch(string field, int unsigned exp_v, int unsigned act_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    err_cnt++;
  endtask

  task automatic check_result(result_t e);
    if (read_data_o !== e.read_data) report_mismatch("read_data", e.read_data, read_data_o);
    if (write_blocked_o !== e.write_blocked)
      report_mismatch("write_blocked", e.write_blocked, write_blocked_o);
    if (watchdog_reset_o !== e.watchdog_reset)
      report_mismatch("watchdog_reset", e.watchdog_reset, watchdog_reset_o);
    if (main_divide_o !== e.main_divide)
      report_mismatch("main_divide", e.main_divide, main_divide_o);
    if (pll_multiply_o !== e.pll_multiply)
      report_mismatch("pll_multiply", e.pll_multiply, pll_multiply_o);
    if (pll_divide_o !== e.pll_divide) report_mismatch("pll_divide", e.pll_divide, pll_divide_o);
    if (clock_selects_o !== e.clock_selects)
      report_mismatch("clock_selects", e.clock_selects, clock_selects_o);
    if (f2n_select_o !== e.f2n_select) report_mismatch("f2n_select", e.f2n_select, f2n_select_o);
    if (config_error_o !== e.config_error)
      report_mismatch("config_error", e.config_error, config_error_o);
  endtask

  // receiver: check each result transfer, stall on a rotating pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual read_data %0h",
                 $time, read_data_o);
        err_cnt++;
      end else begin
        check_result(due_results.pop_front());
      end
    end
    out_ready_i <= stall_pat[stall_idx];
    stall_idx   <= stall_idx + 4'd1;
    if (stall_idx == 4'd15)
      stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom | $urandom);
  end

  initial begin
    item_t   it;
    result_t pred;
    int      n;

    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    mode_i         <= MODE_READ;
    address_i      <= '0;
    write_data_i   <= '0;
    protect_open_i <= 1'b0;
    cpu_tick_i     <= 1'b0;
    ring_tick_i    <= 1'b0;
    regs_reset();

    add_row(mk_item(MODE_READ, ADDR_PM1, 8'h00, 0, 0, 0), 1, at_reset(8'h00, 0, 0));
    add_row(mk_item(MODE_READ, ADDR_CM0, 8'hff, 1, 1, 1), 1, at_reset(8'h08, 0, 0));
    add_row(mk_item(MODE_READ, ADDR_PLC0, 8'h00, 0, 0, 0), 1, at_reset(8'h12, 0, 0));
    add_row(mk_item(MODE_READ, ADDR_WDC, 8'h00, 0, 0, 0), 1, at_reset(8'h00, 0, 0));
    add_row(mk_item(MODE_READ, ADDR_TCSPR, 8'h00, 0, 0, 0), 1, at_reset(8'h00, 0, 0));
    add_row(mk_item(MODE_READ, 10'h3ff, 8'hff, 1, 1, 1), 1, at_reset(8'h00, 0, 0));
    // stopped watchdog: no reset flagged
    add_row(mk_item(MODE_TICK, 10'h000, 8'h00, 0, 1, 1), 1, at_reset(8'h00, 0, 0));
    add_row(mk_item(MODE_WRITE, ADDR_CM0, 8'hff, 0, 0, 0), 1, at_reset(8'h00, 1, 0));
    add_row(mk_item(MODE_WRITE, ADDR_PLC1, 8'hff, 0, 0, 0), 1, at_reset(8'h00, 1, 0));
    add_row(mk_item(MODE_WRITE, ADDR_MCD, 8'h05, 1, 0, 0), 1, at_reset(8'h00, 0, 1));
    add_row(mk_item(MODE_WRITE, ADDR_PLC0, 8'h07, 1, 0, 0), 1, at_reset(8'h00, 0, 1));
    add_row(mk_item(MODE_WRITE, ADDR_MCD, 8'h00, 1, 0, 0), 0, '0);
    add_row(mk_item(MODE_WRITE, ADDR_MCD, 8'h12, 1, 0, 0), 0, '0);
    add_row(mk_item(MODE_WRITE, ADDR_MCD, 8'h12, 1, 0, 0), 0, '0);
    add_row(mk_item(MODE_WRITE, ADDR_PLC0, 8'h03, 1, 0, 0), 0, '0);
    add_row(mk_item(MODE_WRITE, ADDR_PLC1, 8'h04, 1, 0, 0), 0, '0);
    add_row(mk_item(MODE_WRITE, ADDR_PLC0, 8'hfc, 1, 0, 0), 0, '0);
    add_row(mk_item(MODE_WRITE, ADDR_CM0, 8'hff, 1, 0, 0), 0, '0);
    add_row(mk_item(MODE_WRITE, ADDR_PM2, 8'hfb, 0, 0, 0), 0, '0);
    add_row(mk_item(MODE_WRITE, ADDR_PM2, 8'h00, 0, 0, 0), 0, '0);
    add_row(mk_item(MODE_WRITE, ADDR_WDC, 8'h00, 0, 0, 0), 0, '0);
    add_row(mk_item(MODE_WRITE, ADDR_WDTS, 8'h00, 0, 0, 0), 0, '0);
    add_row(mk_item(MODE_READ, ADDR_WDC, 8'h00, 0, 0, 0), 0, '0);
    add_row(mk_item(MODE_WRITE, ADDR_TCSPR, 8'hff, 1, 0, 0), 0, '0);
    add_row(mk_item(MODE_WRITE, 10'h3ff, 8'h00, 1, 0, 0), 0, '0);
    add_row(mk_item(MODE_NONE, 10'h000, 8'hff, 1, 1, 1), 0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res, pred);

    // CPU prescaler mode first: PM2 bit 2 is sticky
    repeat (700) send_item(rand_item(1'b0), 1'b0, '0, pred);
    repeat (700) send_item(rand_item(1'b1), 1'b0, '0, pred);

    // ring mode: count steps down on ring oscillator ticks
    send_item(mk_item(MODE_WRITE, ADDR_PM2, 8'($urandom) | 8'h04, 1, 0, 0), 1'b0, '0, pred);
    send_item(mk_item(MODE_WRITE, ADDR_WDTS, 8'($urandom), 1, 0, 0), 1'b0, '0, pred);
    repeat (150) begin
      it = mk_item(MODE_TICK, 10'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                   $urandom_range(0, 15) != 0);
      send_item(it, 1'b0, '0, pred);
    end
    for (n = 0; n < 20; n++)
      send_item(mk_item(MODE_TICK, 10'h000, 8'h00, 0, 1'($urandom), 1), 1'b0, '0, pred);
    send_item(mk_item(MODE_WRITE, ADDR_WDTS, 8'h00, 1, 0, 0), 1'b0, '0, pred);
    repeat (30) send_item(rand_item(1'b1), 1'b0, '0, pred);

    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
